/* hw/rtl/fnvh_pkg.sv */
// Shared constants and types for the word FNV content hash.
`timescale 1ns / 1ps

package fnvh_pkg;

    localparam int unsigned HashW = 64;

    // Offset seed of the running hash.
    localparam logic [HashW-1:0] HASH_SEED = 64'hcbf2_9ce4_8422_2325;

    // Prime 0x100000001b3 = 2^40 + 0x1b3: one shift plus a narrow product.
    localparam int unsigned     PRIME_SHIFT = 40;
    localparam logic [8:0]      PRIME_LOW   = 9'h1b3;

    localparam int unsigned WORD_SHIFT  = 29;
    localparam int unsigned FINAL_SHIFT = 31;

    // Post-multiply xorshift applied by the mix unit.
    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_WORD  = 2'd1,
        SH_FINAL = 2'd2
    } t_shift_sel;

    typedef struct packed {
        logic [HashW-1:0] operand;
        t_shift_sel       shift;
    } t_mix_req;

endpackage

/* hw/rtl/fnvh_mix.sv */
// Shared mix unit: xor, multiply by the FNV prime, optional xorshift.
`timescale 1ns / 1ps

module fnvh_mix
    import fnvh_pkg::*;
(
    input  logic [HashW-1:0] i_hash,
    input  t_mix_req         i_req,
    output logic [HashW-1:0] o_hash
);

    logic [HashW-1:0]   mixed;
    logic [HashW+8:0]   low_prod;
    logic [HashW-1:0]   prod;

    assign mixed    = i_hash ^ i_req.operand;
    // Low 64 bits of mixed * (2^40 + 0x1b3).
    assign low_prod = mixed * PRIME_LOW;
    assign prod     = (mixed << PRIME_SHIFT) + low_prod[HashW-1:0];

    always_comb begin
        unique case (i_req.shift)
            SH_NONE:  o_hash = prod;
            SH_WORD:  o_hash = prod ^ (prod >> WORD_SHIFT);
            SH_FINAL: o_hash = prod ^ (prod >> FINAL_SHIFT);
            default:  o_hash = prod;
        endcase
    end

endmodule

/* hw/rtl/word_fnv_content_hash.sv */
// Top level of the word FNV content hash: sequencer, state and result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | into      | i_in_valid / o_in_stall    | i_data_word, i_valid_bytes, i_last_item
//  out     | out of    | o_out_valid / i_out_stall  | o_hash_out
//
// After acceptance, a full word is mixed whole in the mix step, while a short word is
// mixed byte by byte, even a zero-byte word passing through the mix step; the single
// shared mix unit sets this. A last transaction adds a finalisation step, which waits
// while the result register is still held by a stalled earlier result.
// Reset is synchronous, active low; it seeds the hash and clears the byte total.
// The input stalls whenever the sequencer is not idle; a waiting result never blocks
// new transactions until the next finalisation needs the register.
`timescale 1ns / 1ps

module word_fnv_content_hash
    import fnvh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [63:0]      i_data_word,
    input  logic [3:0]       i_valid_bytes,
    input  logic             i_last_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [63:0]      o_hash_out
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MIX   = 3'b010,
        S_FINAL = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [63:0]      r_hash, n_hash;
    logic [63:0]      r_total, n_total;
    logic [63:0]      r_word, n_word;     // shifts down a byte per byte step
    logic [3:0]       r_left, n_left;     // bytes still to mix (short word)
    logic             r_full, n_full;
    logic             r_last, n_last;
    logic             r_out_valid, n_out_valid;
    logic [63:0]      r_hash_out, n_hash_out;

    logic             in_acc;
    logic             res_free;           // result register can take a new value
    t_mix_req         mix_req;
    logic [63:0]      mix_hash;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign res_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hash_out  = r_hash_out;

    // Operand and shift for the shared unit, by sequencer step.
    always_comb begin
        mix_req.operand = r_total;
        mix_req.shift   = SH_FINAL;
        if (r_state == S_MIX) begin
            if (r_full) begin
                mix_req.operand = r_word;
                mix_req.shift   = SH_WORD;
            end else begin
                mix_req.operand = {56'd0, r_word[7:0]};
                mix_req.shift   = SH_NONE;
            end
        end
    end

    fnvh_mix u_mix (
        .i_hash (r_hash),
        .i_req  (mix_req),
        .o_hash (mix_hash)
    );

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_total     = r_total;
        n_word      = r_word;
        n_left      = r_left;
        n_full      = r_full;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_hash_out  = r_hash_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    // counts above eight saturate to a full word
                    n_full  = i_valid_bytes[3];
                    n_left  = i_valid_bytes[3] ? 4'd8 : {1'b0, i_valid_bytes[2:0]};
                    n_word  = i_data_word;
                    n_last  = i_last_item;
                    n_total = r_total + {60'd0, n_left};
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                if (r_full) begin
                    n_hash  = mix_hash;
                    n_state = r_last ? S_FINAL : S_IDLE;
                end else if (r_left == 4'd0) begin
                    n_state = r_last ? S_FINAL : S_IDLE;
                end else begin
                    n_hash = mix_hash;
                    n_word = r_word >> 8;
                    n_left = r_left - 4'd1;
                    if (r_left == 4'd1) begin
                        n_state = r_last ? S_FINAL : S_IDLE;
                    end
                end
            end
            S_FINAL: begin
                if (res_free) begin
                    n_hash_out  = mix_hash;
                    n_out_valid = 1'b1;
                    n_hash      = HASH_SEED;
                    n_total     = 64'd0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= HASH_SEED;
            r_total     <= 64'd0;
            r_out_valid <= 1'b0;
            r_left      <= 4'd0;
            r_full      <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
            r_full      <= n_full;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_hash_out <= n_hash_out;
    end

    // An accepted transaction always goes to the mix step.
    a_acc_to_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_MIX))
        else $error("accepted transaction did not enter mix step");

    // A held result is never overwritten by finalisation.
    a_final_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) && r_out_valid && i_out_stall |=> (r_state == S_FINAL))
        else $error("finalisation left while result register busy");

    // Emitting a result reseeds the hash and clears the byte total.
    a_reseed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) && res_free |=> (r_hash == HASH_SEED) && (r_total == 64'd0))
        else $error("state not reseeded after result");

    // The byte countdown never exceeds a word.
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |-> (r_left <= 4'd8))
        else $error("byte countdown out of range");

endmodule

/* bench/tb.sv */
// Self-checking bench for word_fnv_content_hash: queued transactions, scoreboard, random idling.
`timescale 1ns / 1ps

module tb;
    import fnvh_pkg::*;

    // Full 64-bit FNV prime; the package carries it only in split form.
    localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01b3;
    localparam int          N_ITEMS     = 1300;
    // Worst case per transaction: a long gap, a short word mixed byte by byte, finalisation
    // and a long output stall; the limit stays well above that for all transactions.
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          LONG_HOLD   = 400;  // receiver hold-off, in cycles
    localparam int          HOLD_AT     = 400;  // accepted transactions before hold-off
    localparam int          TAIL_CYCLES = 40;   // settle time after last result

    // One queued input transaction plus its pacing.
    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
        int unsigned pre_gap;     // idle cycles before it is offered
        bit          drain_first; // hold back until no hash is outstanding
    } t_txn;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [63:0] i_data_word = '0;
    logic [3:0]  i_valid_bytes = '0;
    logic        i_last_item = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_hash_out;

    t_txn        pending[$];      // transactions still to be driven
    logic [63:0] hash_expect[$];  // predicted digests, oldest first

    // Predictor state: mirrors the block's running hash and byte count.
    logic [63:0] hash_acc;
    logic [63:0] byte_count;

    int unsigned n_accepted = 0;
    int unsigned n_errors = 0;
    int unsigned n_cycles = 0;

    // Driver scratch state.
    t_txn        staged_txn;
    bit          staged = 1'b0;
    int unsigned gap_left = 0;

    // Receiver stall state.
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    word_fnv_content_hash dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_item   (i_last_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hash_out    (o_hash_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mix one accepted transaction into the predicted state. Returns 1 and the
    // finished digest when the transaction closes a message.
    function automatic bit absorb_txn(input logic [63:0] data, input logic [3:0] nbytes,
                                      input logic last, output logic [63:0] digest);
        logic [63:0] h;
        logic [3:0]  n;
        h      = hash_acc;
        digest = '0;
        // Counts above eight saturate, so the transaction is taken as a full word.
        n = (nbytes > 4'd8) ? 4'd8 : nbytes;
        if (n == 4'd8) begin
            h = (h ^ data) * FNV_PRIME;
            h = h ^ (h >> WORD_SHIFT);
        end else begin
            // Short word: bytewise, lowest byte first; bytes beyond the count are ignored.
            for (int k = 0; k < n; k++) begin
                h = (h ^ {56'd0, data[8*k +: 8]}) * FNV_PRIME;
            end
        end
        byte_count = byte_count + 64'(n);
        if (!last) begin
            hash_acc = h;
            return 1'b0;
        end
        // Finalise: fold in the byte count, xorshift, then back to the seed.
        h          = (h ^ byte_count) * FNV_PRIME;
        digest     = h ^ (h >> FINAL_SHIFT);
        hash_acc   = HASH_SEED;
        byte_count = '0;
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 65) return 0;
        if (r < 88)          return $urandom_range(1, 3);
        if (r < 97)          return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random data word, with the odd all-zero or all-one pattern.
    function automatic logic [63:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic queue_txn(input logic [63:0] data, input logic [3:0] nbytes,
                             input logic last, input int unsigned gap, input bit drain);
        t_txn t;
        t.data        = data;
        t.nbytes      = nbytes;
        t.last        = last;
        t.pre_gap     = gap;
        t.drain_first = drain;
        pending.insert(pending.size(), t);
    endtask

    // Driver: predicts on each accepted transaction, then offers the next one.
    always @(posedge i_clk) begin : drive_in
        bit          take;
        bit          vld;
        logic [63:0] digest;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            hash_acc   = HASH_SEED;
            byte_count = '0;
        end else begin
            take = i_in_valid && !o_in_stall;
            if (take) begin
                n_accepted++;
                if (absorb_txn(i_data_word, i_valid_bytes, i_last_item, digest))
                    hash_expect.insert(hash_expect.size(), digest);
            end
            // A stalled transaction stays put; otherwise fetch or count down a gap.
            if (!i_in_valid || take) begin
                vld = 1'b0;
                if (!staged && pending.size() != 0 &&
                    !(pending[0].drain_first && hash_expect.size() != 0)) begin
                    staged_txn = pending.pop_front();
                    staged     = 1'b1;
                    gap_left   = staged_txn.pre_gap;
                end
                if (staged && gap_left == 0) begin
                    i_data_word   <= staged_txn.data;
                    i_valid_bytes <= staged_txn.nbytes;
                    i_last_item   <= staged_txn.last;
                    staged = 1'b0;
                    vld    = 1'b1;
                end else if (staged) begin
                    gap_left--;
                end
                i_in_valid <= vld;
            end
        end
    end

    // Receiver back-pressure: random stalls, calm stretches, and one long hold-off.
    always @(posedge i_clk) begin : drive_stall
        int unsigned r;
        int unsigned len;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ((n_accepted / 150) % 3 == 2) begin
                i_out_stall <= 1'b0;  // calm stretch
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)      len = 0;
                else if (r < 90) len = $urandom_range(1, 3);
                else if (r < 98) len = $urandom_range(4, 12);
                else             len = $urandom_range(20, 60);
                stall_left = (len != 0) ? len - 1 : 0;
                i_out_stall <= (len != 0);
            end
        end
    end

    // Scoreboard: each delivered hash against the oldest prediction.
    always @(posedge i_clk) begin : check_out
        logic [63:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (hash_expect.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected hash %h at cycle %0d", o_hash_out, n_cycles);
            end else begin
                want = hash_expect.pop_front();
                if (o_hash_out !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: hash_out exp %h got %h at cycle %0d",
                                 want, o_hash_out, n_cycles);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin : watchdog
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("ERROR: timeout, %0d hashes outstanding", hash_expect.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned msg_idx;
        int unsigned len;
        int unsigned r;
        bit          burst;
        bit          drain;
        logic [3:0]  nb;

        // Directed: field extremes and each corner of the byte count.
        queue_txn('0, 4'd0, 1'b1, 0, 1'b0);            // empty message, finalise only
        queue_txn('1, 4'd8, 1'b1, 0, 1'b0);            // all-ones full word
        queue_txn('0, 4'd8, 1'b1, 0, 1'b0);            // all-zero full word
        queue_txn(pick_word(), 4'd15, 1'b1, 0, 1'b0);  // count saturates to a full word
        queue_txn('1, 4'd9, 1'b0, 1, 1'b0);
        queue_txn('1, 4'd12, 1'b1, 0, 1'b0);
        for (int n = 1; n < 8; n++)                    // short words, junk above the count
            queue_txn('1, 4'(n), 1'b1, n % 2, 1'b0);
        // Multi-transaction message: full words, a short tail, then an empty closer.
        queue_txn(64'h0123_4567_89ab_cdef, 4'd8, 1'b0, 0, 1'b0);
        queue_txn(64'hfedc_ba98_7654_3210, 4'd8, 1'b0, 0, 1'b0);
        queue_txn(pick_word(), 4'd3, 1'b0, 2, 1'b0);
        queue_txn(pick_word(), 4'd0, 1'b0, 0, 1'b0);   // empty, not last
        queue_txn(pick_word(), 4'd0, 1'b1, 0, 1'b0);
        // Short word mid-message followed by full words.
        queue_txn(pick_word(), 4'd5, 1'b0, 0, 1'b0);
        queue_txn(pick_word(), 4'd8, 1'b0, 0, 1'b0);
        queue_txn(pick_word(), 4'd8, 1'b1, 0, 1'b0);
        queue_txn(pick_word(), 4'd7, 1'b1, 0, 1'b1);   // after a full drain

        // Random messages: mostly full words, each closed by a word of any byte count.
        msg_idx = 0;
        while (pending.size() < N_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 7)      len = $urandom_range(1, 6);
            else if (r < 9) len = $urandom_range(7, 20);
            else            len = 1;
            burst = ($urandom_range(0, 9) < 3);
            drain = (msg_idx == 60 || msg_idx == 200);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (i == len - 1)  nb = 4'($urandom_range(0, 15));
                else if (r < 80)   nb = 4'd8;
                else if (r < 95)   nb = 4'($urandom_range(0, 7));
                else               nb = 4'($urandom_range(9, 15));
                queue_txn(pick_word(), nb, (i == len - 1), pick_gap(burst), drain && i == 0);
            end
            msg_idx++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every transaction taken and every hash delivered, then settle.
        while (pending.size() != 0 || staged || i_in_valid || hash_expect.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && hash_expect.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("ERROR: %0d mismatches, %0d hashes missing", n_errors, hash_expect.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
